>>> rtl/spcd_pkg.sv
// ----------------------------------------------------------------------------
// spcd_pkg
// Shared types, constants and pair tables for the sprite pair collision block.
// ----------------------------------------------------------------------------
package spcd_pkg;

  localparam int NumSprites = 4;
  localparam int NumRows    = 8;
  localparam int NumPairs   = 6;

  localparam int RowDepth   = NumSprites * NumRows;
  localparam int PosDepth   = 2 * NumSprites;

  // Bus decode: positions at 0xF0-0xF7, pattern rows at 0x180-0x19F
  localparam logic [6:0] PosPage = 7'b0011110;
  localparam logic [4:0] RowPage = 5'b01100;

  localparam logic [8:0] XOffset = 9'd44;
  localparam logic [8:0] YOffset = 9'd16;
  localparam logic [5:0] NoHits  = 6'h3F;

  localparam logic OpWrite = 1'b0;
  localparam logic OpFrame = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POS_X,
    ST_POS_Y,
    ST_CHECK,
    ST_ROWS,
    ST_FINISH
  } spcd_state_t;

  // First sprite of each pair, pair order 01 02 03 12 13 23
  function automatic logic [1:0] pair_first(input logic [2:0] p);
    logic [1:0] s;
    case (p)
      3'd0, 3'd1, 3'd2: s = 2'd0;
      3'd3, 3'd4:       s = 2'd1;
      default:          s = 2'd2;
    endcase
    return s;
  endfunction

  // Second sprite of each pair
  function automatic logic [1:0] pair_second(input logic [2:0] p);
    logic [1:0] s;
    case (p)
      3'd0:       s = 2'd1;
      3'd1, 3'd3: s = 2'd2;
      default:    s = 2'd3;
    endcase
    return s;
  endfunction

endpackage

>>> rtl/spcd_if.sv
// ----------------------------------------------------------------------------
// spcd_cmd_if / spcd_result_if
// Valid/ready channels for bus commands and collision results.
// ----------------------------------------------------------------------------
interface spcd_cmd_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [9:0] address;
  logic [7:0] write_data;

  modport source (output valid, output opcode, output address, output write_data,
                  input ready);
  modport sink   (input valid, input opcode, input address, input write_data,
                  output ready);
endinterface

interface spcd_result_if;
  logic       valid;
  logic       ready;
  logic [5:0] sprite_collision;

  modport source (output valid, output sprite_collision, input ready);
  modport sink   (input valid, input sprite_collision, output ready);
endinterface

>>> rtl/spcd_ram.sv
// ----------------------------------------------------------------------------
// spcd_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module spcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and register both reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

>>> rtl/sprite_pair_collision_detect.sv
// ----------------------------------------------------------------------------
// sprite_pair_collision_detect
// Tracks four 8x8 sprites from bus writes and tests the six sprite pairs for
// overlapping set pixels at each end-of-frame event.
// ----------------------------------------------------------------------------
// A bus write (opcode 0) returns nothing; writes can be sent back to back,
// also while a collision result waits to be taken. An end-of-frame event
// (opcode 1) walks the pairs 01, 02, 03, 12, 13, 23 in turn: for each pair
// the states POS_X, POS_Y and CHECK read and compare the positions, and
// when the pair is within 7 pixels on both axes ROWS follows, reading the
// eight pattern rows, one row of each sprite per cycle from the row memory,
// with the compare of each row pair registered behind its read. The 6-bit
// active-low result is shown from FINISH once the last row compare is done,
// later while an earlier result still waits, and the block takes no command
// from the frame transfer until then. Both memories start out as zero after
// reset through per-entry valid bits, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module sprite_pair_collision_detect
  import spcd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  spcd_cmd_if.sink     cmd,
  spcd_result_if.source result
);

  localparam int RowAw = $clog2(RowDepth);
  localparam int PosAw = $clog2(PosDepth);

  spcd_state_t state, state_next;

  logic [2:0] pair;
  logic [2:0] k;
  logic [5:0] res_acc;
  logic [5:0] res_data;
  logic       res_valid;

  logic [RowDepth-1:0] row_valid;
  logic [PosDepth-1:0] pos_valid;

  logic             cmd_fire;
  logic             row_we, pos_we;
  logic [RowAw-1:0] row_waddr;
  logic [PosAw-1:0] pos_waddr;
  logic [8:0]       pos_wdata;

  logic [RowAw-1:0] row_raddr_a, row_raddr_b;
  logic [PosAw-1:0] pos_raddr_a, pos_raddr_b;
  logic [7:0]       row_rdata_a, row_rdata_b;
  logic [8:0]       pos_rdata_a, pos_rdata_b;
  logic             row_rv_a, row_rv_b, pos_rv_a, pos_rv_b;

  logic [1:0] spr_a, spr_b;
  logic [8:0] pos_a, pos_b;
  logic [9:0] diff;
  logic       diff_near;
  logic [3:0] dx, dy;
  logic       dx_near;
  logic [4:0] j;
  logic       j_ok;

  logic       pend, pend_jv;
  logic [2:0] pend_pair;
  logic [7:0] ra, rb, rb_shift;
  logic [2:0] dx_mag;
  logic       hit;
  logic       finish_go;

  assign cmd_fire  = cmd.valid && cmd.ready;
  assign spr_a     = pair_first(pair);
  assign spr_b     = pair_second(pair);

  // Decode bus writes into the two memories
  assign row_we    = cmd_fire && (cmd.opcode == OpWrite) && (cmd.address[9:5] == RowPage);
  assign pos_we    = cmd_fire && (cmd.opcode == OpWrite) && (cmd.address[9:3] == PosPage);
  assign row_waddr = cmd.address[RowAw-1:0];
  assign pos_waddr = cmd.address[PosAw-1:0];
  assign pos_wdata = cmd.address[0] ? ({1'b0, cmd.write_data} - XOffset)
                                    : ({1'b0, ~cmd.write_data} - YOffset);

  // Masked read data: an entry never written reads as zero
  assign pos_a = pos_rv_a ? pos_rdata_a : 9'd0;
  assign pos_b = pos_rv_b ? pos_rdata_b : 9'd0;
  assign ra    = row_rv_a ? row_rdata_a : 8'd0;
  assign rb    = row_rv_b ? row_rdata_b : 8'd0;

  // Position difference of the pair, signed, and whether it is within 7
  assign diff      = {pos_b[8], pos_b} - {pos_a[8], pos_a};
  assign diff_near = ($signed(diff) >= -10'sd7) && ($signed(diff) <= 10'sd7);

  // Row of the second sprite on the same screen line
  assign j    = {2'b00, k} - {dy[3], dy};
  assign j_ok = (j[4:3] == 2'b00);

  // Align the second row by the true horizontal distance and test overlap
  assign dx_mag   = dx[3] ? 3'(-dx) : dx[2:0];
  assign rb_shift = dx[3] ? (rb << dx_mag) : (rb >> dx_mag);
  assign hit      = pend && pend_jv && ((ra & rb_shift) != 8'd0);

  assign finish_go = !pend && (!res_valid || result.ready);

  assign result.valid            = res_valid;
  assign result.sprite_collision = res_data;

  spcd_ram #(.WIDTH(8), .DEPTH(RowDepth)) u_row_ram (
    .clk     (clk),
    .we      (row_we),
    .waddr   (row_waddr),
    .wdata   (cmd.write_data),
    .raddr_a (row_raddr_a),
    .rdata_a (row_rdata_a),
    .raddr_b (row_raddr_b),
    .rdata_b (row_rdata_b)
  );

  spcd_ram #(.WIDTH(9), .DEPTH(PosDepth)) u_pos_ram (
    .clk     (clk),
    .we      (pos_we),
    .waddr   (pos_waddr),
    .wdata   (pos_wdata),
    .raddr_a (pos_raddr_a),
    .rdata_a (pos_rdata_a),
    .raddr_b (pos_raddr_b),
    .rdata_b (pos_rdata_b)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd_fire && (cmd.opcode == OpFrame)) begin
          state_next = ST_POS_X;
        end
      end
      ST_POS_X: state_next = ST_POS_Y;
      ST_POS_Y: state_next = ST_CHECK;
      ST_CHECK: begin
        if (dx_near && diff_near) begin
          state_next = ST_ROWS;
        end else if (pair == 3'(NumPairs - 1)) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_POS_X;
        end
      end
      ST_ROWS: begin
        if (k == 3'(NumRows - 1)) begin
          state_next = (pair == 3'(NumPairs - 1)) ? ST_FINISH : ST_POS_X;
        end
      end
      ST_FINISH: begin
        if (finish_go) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Memory read addresses and handshake outputs
  always_comb begin
    cmd.ready   = 1'b0;
    pos_raddr_a = {spr_a, 1'b1};
    pos_raddr_b = {spr_b, 1'b1};
    row_raddr_a = {spr_a, k};
    row_raddr_b = {spr_b, j[2:0]};
    unique case (state)
      ST_IDLE:  cmd.ready = 1'b1;
      ST_POS_Y: begin
        pos_raddr_a = {spr_a, 1'b0};
        pos_raddr_b = {spr_b, 1'b0};
      end
      default: ;
    endcase
  end

  // Control state, valid bits and sequencer counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      row_valid <= '0;
      pos_valid <= '0;
      res_valid <= 1'b0;
      pend      <= 1'b0;
      pair      <= 3'd0;
      k         <= 3'd0;
    end else begin
      state <= state_next;
      pend  <= (state == ST_ROWS);
      if (row_we) begin
        row_valid[row_waddr] <= 1'b1;
      end
      if (pos_we) begin
        pos_valid[pos_waddr] <= 1'b1;
      end
      // raise a new result, else drop the one just transferred
      if ((state == ST_FINISH) && finish_go) begin
        res_valid <= 1'b1;
      end else if (result.valid && result.ready) begin
        res_valid <= 1'b0;
      end
      // advance pair and row counters
      unique case (state)
        ST_IDLE:  pair <= 3'd0;
        ST_CHECK: begin
          k <= 3'd0;
          if (!(dx_near && diff_near)) begin
            pair <= pair + 3'd1;
          end
        end
        ST_ROWS: begin
          k <= k + 3'd1;
          if (k == 3'(NumRows - 1)) begin
            pair <= pair + 3'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    row_rv_a <= row_valid[row_raddr_a];
    row_rv_b <= row_valid[row_raddr_b];
    pos_rv_a <= pos_valid[pos_raddr_a];
    pos_rv_b <= pos_valid[pos_raddr_b];
    if (state == ST_POS_Y) begin
      dx      <= diff[3:0];
      dx_near <= diff_near;
    end
    if (state == ST_CHECK) begin
      dy <= diff[3:0];
    end
    if (state == ST_ROWS) begin
      pend_jv   <= j_ok;
      pend_pair <= pair;
    end
    // accumulate active-low collision bits
    if (state == ST_IDLE) begin
      res_acc <= NoHits;
    end else if (hit) begin
      res_acc[pend_pair] <= 1'b0;
    end
    if ((state == ST_FINISH) && finish_go) begin
      res_data <= res_acc;
    end
  end

  // Memories are written only while no frame event is in progress
  assert property (@(posedge clk) disable iff (rst)
    (row_we || pos_we) |-> (state == ST_IDLE))
    else $error("memory write during collision walk");

  // A frame event starts the walk at the first pair
  assert property (@(posedge clk) disable iff (rst)
    (cmd_fire && (cmd.opcode == OpFrame)) |=> ((state == ST_POS_X) && (pair == 3'd0)))
    else $error("frame event did not start the walk");

  // Row reads always begin at row zero
  assert property (@(posedge clk) disable iff (rst)
    ((state == ST_CHECK) && (state_next == ST_ROWS)) |=> (k == 3'd0))
    else $error("row walk did not start at row zero");

  // No row compare is left over once the block is idle
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !pend)
    else $error("row compare pending while idle");

  // Pair index stays within the six pairs during the walk
  assert property (@(posedge clk) disable iff (rst)
    ((state == ST_POS_X) || (state == ST_ROWS)) |-> (pair < 3'(NumPairs)))
    else $error("pair index out of range");

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sprite pair collision block. It places sprites
// and loads patterns over the command channel, raises end-of-frame events
// and compares each 6-bit active-low collision result against a local
// scene model. Directed tests cover bus decode edges, position extremes
// and the near/far limits. Random scenes then cluster sprites close
// together so that overlaps are common. Sender bursts and receiver stalls
// vary throughout the run.
// ----------------------------------------------------------------------------
module tb_top;
  import spcd_pkg::*;

  localparam logic [9:0] PosFirst = 10'h0F0;
  localparam logic [9:0] PosLast  = 10'h0F7;
  localparam logic [9:0] RowFirst = 10'h180;
  localparam logic [9:0] RowLast  = 10'h19F;

  localparam int RandomItems = 650;
  localparam int MinFrames   = 40;
  localparam int DrainCycles = 100;

  logic clk = 1'b0;
  logic rst = 1'b1;

  spcd_cmd_if    cmd_ch ();
  spcd_result_if res_ch ();

  sprite_pair_collision_detect dut (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd_ch),
    .result (res_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Scene model: pattern rows and signed screen positions
  logic [7:0]        pat_rows [RowDepth];
  logic signed [8:0] spr_x [NumSprites];
  logic signed [8:0] spr_y [NumSprites];

  logic [5:0] collision_q [$];
  int         fail_count = 0;
  int         burst_left = 0;
  int         stall_hold = 0;
  logic       stall_ready = 1'b0;

  function automatic logic [9:0] pos_addr(input int n, input bit is_x);
    return PosFirst + 10'(2 * n) + 10'(is_x);
  endfunction

  function automatic logic [9:0] row_addr(input int n, input int r);
    return RowFirst + 10'(NumRows * n + r);
  endfunction

  function automatic bit addr_acts(input logic [9:0] addr);
    return (addr >= PosFirst && addr <= PosLast) || (addr >= RowFirst && addr <= RowLast);
  endfunction

  // Update the scene on an accepted bus write
  task automatic apply_write(input logic [9:0] addr, input logic [7:0] data);
    if (addr >= PosFirst && addr <= PosLast) begin
      if (addr[0]) begin
        spr_x[addr[2:1]] = $signed({1'b0, data}) - $signed(XOffset);
      end else begin
        spr_y[addr[2:1]] = $signed({1'b0, data ^ 8'hFF}) - $signed(YOffset);
      end
    end else if (addr >= RowFirst && addr <= RowLast) begin
      pat_rows[{addr[4:3], addr[2:0]}] = data;
    end
  endtask

  // True when sprites a and b share a set pixel on some screen line
  function automatic bit pair_overlaps(input int a, input int b);
    int dx;
    int dy;
    int j;
    logic [31:0] row_a;
    logic [31:0] row_b;
    dx = spr_x[b] - spr_x[a];
    dy = spr_y[b] - spr_y[a];
    if (dx >= 8 || dx <= -8 || dy >= 8 || dy <= -8) return 1'b0;
    for (int k = 0; k < NumRows; k++) begin
      j = k - dy;
      if (j >= 0 && j < NumRows) begin
        row_a = 32'(pat_rows[a * NumRows + k]) << 8;
        row_b = 32'(pat_rows[b * NumRows + j]) << 8;
        if (dx >= 0) row_b = row_b >> dx;
        else row_b = row_b << (-dx);
        if ((row_a & row_b) != 0) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Pair order 01 02 03 12 13 23 falls out of the nested loop
  function automatic logic [5:0] predict_collisions();
    logic [5:0] hits;
    int p;
    hits = NoHits;
    p = 0;
    for (int a = 0; a < NumSprites - 1; a++) begin
      for (int b = a + 1; b < NumSprites; b++) begin
        if (pair_overlaps(a, b)) hits[p] = 1'b0;
        p++;
      end
    end
    return hits;
  endfunction

  // Drive one command, with random bursts and gaps, and model it on transfer
  task automatic send_cmd(input logic op, input logic [9:0] addr, input logic [7:0] data);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        cmd_ch.address <= 10'($urandom_range(0, 1023));
      end
    end
    burst_left--;
    @(negedge clk);
    cmd_ch.valid      <= 1'b1;
    cmd_ch.opcode     <= op;
    cmd_ch.address    <= addr;
    cmd_ch.write_data <= data;
    do @(posedge clk); while (!cmd_ch.ready);
    if (op == OpFrame) collision_q.push_back(predict_collisions());
    else apply_write(addr, data);
  endtask

  task automatic send_frame();
    send_cmd(OpFrame, 10'($urandom_range(0, 1023)), 8'($urandom_range(0, 255)));
  endtask

  // Hold ready in segments: long stalls, clear stretches, or per-cycle noise
  always @(negedge clk) begin
    if (stall_hold == 0) begin
      case ($urandom_range(0, 3))
        0: begin
          stall_ready = 1'b0;
          stall_hold  = $urandom_range(1, 20);
        end
        1: begin
          stall_ready = 1'b1;
          stall_hold  = $urandom_range(1, 40);
        end
        default: begin
          stall_ready = 1'($urandom_range(0, 1));
          stall_hold  = 0;
        end
      endcase
    end else begin
      stall_hold--;
    end
    res_ch.ready <= stall_ready;
  end

  // Check each result transfer against the oldest prediction
  always @(posedge clk) begin : check_results
    logic [5:0] expected;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (collision_q.size() == 0) begin
        $error("sprite_collision: expected none, actual %h", res_ch.sprite_collision);
        fail_count++;
      end else begin
        expected = collision_q.pop_front();
        if (res_ch.sprite_collision !== expected) begin
          $error("sprite_collision: expected %h, actual %h", expected,
                 res_ch.sprite_collision);
          fail_count++;
        end
      end
    end
  end

  // All state is zero after reset, so nothing collides
  task automatic test_reset_state();
    send_cmd(OpFrame, '1, 8'hFF);
  endtask

  // Writes just outside the active windows must leave the scene alone
  task automatic test_address_decode();
    send_cmd(OpWrite, row_addr(0, 0), 8'h80);
    send_cmd(OpWrite, row_addr(1, 0), 8'h80);
    send_frame();
    send_cmd(OpWrite, RowLast + 10'd1, 8'h00);
    send_cmd(OpWrite, RowFirst - 10'd1, 8'h00);
    send_cmd(OpWrite, PosLast + 10'd1, 8'h00);
    send_cmd(OpWrite, PosFirst - 10'd1, 8'h00);
    send_cmd(OpWrite, '0, 8'hFF);
    send_frame();
  endtask

  // Distance of 8 on either axis never collides; 7 can
  task automatic test_far_apart();
    send_cmd(OpWrite, row_addr(0, 0), 8'hFF);
    send_cmd(OpWrite, row_addr(1, 0), 8'hFF);
    send_cmd(OpWrite, pos_addr(0, 1'b1), 8'd100);
    send_cmd(OpWrite, pos_addr(1, 1'b1), 8'd108);
    send_frame();
    send_cmd(OpWrite, pos_addr(1, 1'b1), 8'd107);
    send_frame();
    send_cmd(OpWrite, pos_addr(1, 1'b1), 8'd93);
    send_frame();
    send_cmd(OpWrite, pos_addr(0, 1'b0), 8'h80);
    send_cmd(OpWrite, pos_addr(1, 1'b0), 8'h78);
    send_frame();
  endtask

  // Position bytes at both ends and the last pattern row
  task automatic test_extremes();
    send_cmd(OpWrite, pos_addr(2, 1'b1), 8'h00);
    send_cmd(OpWrite, pos_addr(3, 1'b1), 8'hFF);
    send_cmd(OpWrite, pos_addr(2, 1'b0), 8'h00);
    send_cmd(OpWrite, pos_addr(3, 1'b0), 8'hFF);
    send_cmd(OpWrite, RowLast, 8'hFF);
    send_frame();
  endtask

  function automatic logic [7:0] random_row();
    case ($urandom_range(0, 3))
      0:       return 8'($urandom_range(0, 255));
      1:       return 8'h01 << $urandom_range(0, 7);
      2:       return 8'hFF;
      default: return 8'($urandom_range(0, 255)) & 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] near_byte(input int anchor);
    int v;
    v = anchor + $urandom_range(0, 18) - 9;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  // Random scenes: clustered sprites, fresh rows, some noise, then a frame
  task automatic test_random_scenes();
    int items;
    int frames;
    int anchor_x;
    int anchor_y;
    int n_rows;
    logic [9:0] noise_addr;
    items  = 0;
    frames = 0;
    while (items < RandomItems || frames < MinFrames) begin
      anchor_x = $urandom_range(0, 255);
      anchor_y = $urandom_range(0, 255);
      for (int n = 0; n < NumSprites; n++) begin
        if ($urandom_range(0, 3) != 0) begin
          send_cmd(OpWrite, pos_addr(n, 1'b1), ($urandom_range(0, 3) != 0) ?
                   near_byte(anchor_x) : 8'($urandom_range(0, 255)));
          items++;
        end
        if ($urandom_range(0, 3) != 0) begin
          send_cmd(OpWrite, pos_addr(n, 1'b0), ($urandom_range(0, 3) != 0) ?
                   near_byte(anchor_y) : 8'($urandom_range(0, 255)));
          items++;
        end
      end
      n_rows = $urandom_range(0, 12);
      repeat (n_rows) begin
        send_cmd(OpWrite, row_addr($urandom_range(0, 3), $urandom_range(0, 7)), random_row());
        items++;
      end
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          noise_addr = 10'($urandom_range(0, 1023));
          send_cmd(OpWrite, noise_addr, 8'($urandom_range(0, 255)));
          if (addr_acts(noise_addr)) items++;
        end
      end
      send_frame();
      items++;
      frames++;
      if ($urandom_range(0, 7) == 0) begin
        send_frame();
        items++;
        frames++;
      end
    end
  endtask

  initial begin
    cmd_ch.valid      = 1'b0;
    cmd_ch.opcode     = OpWrite;
    cmd_ch.address    = '0;
    cmd_ch.write_data = '0;
    res_ch.ready      = 1'b0;
    for (int i = 0; i < RowDepth; i++) pat_rows[i] = '0;
    for (int n = 0; n < NumSprites; n++) begin
      spr_x[n] = '0;
      spr_y[n] = '0;
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_address_decode();
    test_far_apart();
    test_extremes();
    test_random_scenes();

    @(negedge clk);
    cmd_ch.valid <= 1'b0;
    wait (collision_q.size() == 0);
    repeat (DrainCycles) @(posedge clk);

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Stop a hung run well past the slowest legal one
  initial begin
    #5000000;
    $display("status: fail");
    $finish;
  end

endmodule
